>>> src/fsnc_pkg.sv
// Package with payload types, constants and floating-point helper functions.
`timescale 1ns / 1ps
`default_nettype none
package fsnc_pkg;

    // Element format codes.
    localparam logic [1:0] FMT_FP32 = 2'd0;
    localparam logic [1:0] FMT_FP16 = 2'd1;
    localparam logic [1:0] FMT_BF16 = 2'd2;

    // Configuration register indexes.
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_STATS  = 1'b1;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] FP32_MAX  = 32'h7F7F_FFFF;
    localparam logic [31:0] FP16_MAX  = 32'h477F_E000;
    localparam logic [31:0] BF16_MAX  = 32'h7F7F_0000;

    typedef struct packed {
        logic [31:0] element_bits;
        logic        last_element;
    } in_item_t;

    typedef struct packed {
        logic [31:0] total_sum;
        logic [31:0] total_abs_sum;
        logic [31:0] min_value;
        logic [31:0] max_value;
        logic        saw_zero;
        logic        saw_nan;
        logic        saw_inf;
    } out_item_t;

    function automatic logic is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // Widen fp16 exactly to fp32, subnormals normalised by a leading-one search.
    function automatic logic [31:0] fp16_to_fp32(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [9:0]  mn;
        logic [7:0]  e32;
        logic [3:0]  lz;
        logic        found;
        e = h[14:10];
        m = h[9:0];
        lz = 4'd0;
        found = 1'b0;
        for (int i = 9; i >= 0; i--) begin
            if (!found && m[i]) begin
                found = 1'b1;
                lz = 4'(9 - i);
            end
        end
        mn = 10'(m << (lz + 4'd1));
        e32 = 8'd113 - 8'(lz) - 8'd1;
        if (e == 5'd31)
            return {h[15], 8'hFF, m, 13'd0};
        else if (e == 5'd0)
            return (m == 10'd0) ? {h[15], 31'd0} : {h[15], e32, mn, 13'd0};
        else
            return {h[15], 8'(e) + 8'd112, m, 13'd0};
    endfunction

    // Ordered less-than on non-NaN fp32 values; +0 and -0 compare equal.
    function automatic logic fp_less(input logic [31:0] a, input logic [31:0] b);
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            return 1'b0;
        else if (a[31] != b[31])
            return a[31];
        else if (a[31])
            return a[30:0] > b[30:0];
        else
            return a[30:0] < b[30:0];
    endfunction

    // fp32 add with round-to-nearest-even; NaN results canonical.
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [26:0] mx;
        logic [26:0] my;
        logic [26:0] sh;
        logic        st;
        logic [27:0] s;
        logic [4:0]  lz;
        logic        found;
        logic [9:0]  er;
        logic [27:0] n;
        logic [23:0] mr;
        logic        rnd;
        logic [24:0] mm;
        logic [9:0]  ef;
        logic        sub;
        // Infinities and NaNs first.
        if (is_nan(a) || is_nan(b))
            return CANON_NAN;
        if (a[30:23] == 8'hFF && b[30:23] == 8'hFF)
            return (a[31] == b[31]) ? a : CANON_NAN;
        if (a[30:23] == 8'hFF)
            return a;
        if (b[30:23] == 8'hFF)
            return b;
        // Order by magnitude.
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx = {(x[30:23] != 8'd0), x[22:0], 3'b000};
        my = {(y[30:23] != 8'd0), y[22:0], 3'b000};
        d = ex - ey;
        sh = (d > 8'd26) ? 27'd0 : (my >> d);
        st = (d > 8'd26) ? (my != 27'd0) : ((sh << d) != my);
        sub = x[31] ^ y[31];
        if (sub)
            s = {1'b0, mx} - {1'b0, sh} - {27'd0, st};
        else
            s = {1'b0, mx} + {1'b0, sh};
        if (s == 28'd0 && !st)
            return (x[31] & y[31]) ? 32'h8000_0000 : 32'd0;
        // Normalise: leading one to bit 26 (value 1.x with bits [25:3]).
        lz = 5'd0;
        found = 1'b0;
        for (int i = 27; i >= 0; i--) begin
            if (!found && s[i]) begin
                found = 1'b1;
                lz = 5'(27 - i);
            end
        end
        er = {2'b00, ex} + 10'd1 - 10'(lz);
        if (lz == 5'd0) begin
            n = s;
            st = st | s[0];
            n = {1'b0, s[27:1]};
        end else if ($signed(er) >= 10'sd1) begin
            n = s << (lz - 5'd1);
        end else begin
            // Subnormal result: shift only as far as exponent one allows.
            n = s << (5'(ex) - 5'd1);
            er = 10'd0;
        end
        // n[26] leading one (or zero for subnormal), n[25:3] fraction, n[2:0] guard.
        mr = n[26:3];
        rnd = n[2] & (n[1] | n[0] | st | mr[0]);
        mm = {1'b0, mr} + {24'd0, rnd};
        ef = (er == 10'd0) ? (mm[23] ? 10'd1 : 10'd0) : er;
        if (mm[24]) begin
            mm = mm >> 1;
            ef = ef + 10'd1;
        end
        if (ef >= 10'd255)
            return {x[31], 8'hFF, 23'd0};
        return {x[31], ef[7:0], mm[22:0]};
    endfunction

endpackage
`default_nettype wire

>>> src/float_stream_numerics_checker_unit.sv
// Top level of the streaming floating-point sum, min/max and NaN/Inf checker.
//
// Usage: elements arrive on the input channel (in_valid/in_stall/in_data), one per
// transfer. Each is widened to fp32 per the format register, added to the running
// sum and absolute sum, and folded into the min, max and sticky flags. The transfer
// marked last produces one result transfer on the output channel with the totals,
// then the running state is cleared for the next tensor.
// The result is registered and appears in the cycle after the last element's transfer.
// Throughput: one element per cycle unless the input is stalled; the accumulator is one
// combinational fp32 adder between the running-sum register and itself, which sets the clock period.
// The input is stalled, for every element, only while a finished result waits and
// the receiver stalls the output.
// Reset clears the running state and the output valid flag, and sets format fp32 and
// statistics enabled. Configuration writes take effect on the next element.
`timescale 1ns / 1ps
`default_nettype none
module float_stream_numerics_checker_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire fsnc_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output fsnc_pkg::out_item_t      out_data,
    input  wire logic                cfg_write,
    input  wire logic                cfg_index,
    input  wire logic [1:0]          cfg_data
);

    logic [1:0]  format_reg;
    logic        stats_reg;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] abs_reg, abs_next;
    logic [31:0] min_reg, min_next;
    logic [31:0] max_reg, max_next;
    logic        mm_valid_reg, mm_valid_next;
    logic [2:0]  flags_reg, flags_next;
    logic        out_valid_reg;
    fsnc_pkg::out_item_t out_reg, out_next;
    logic [31:0] v;
    logic [31:0] fmax;
    logic        accept;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= fsnc_pkg::FMT_FP32;
            stats_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fsnc_pkg::REG_FORMAT: format_reg <= cfg_data;
                fsnc_pkg::REG_STATS:  stats_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input is blocked, for every element, while a waiting result is stalled.
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // Widen and accumulate.
    always_comb
    begin
        case (format_reg)
            fsnc_pkg::FMT_FP16: v = fsnc_pkg::fp16_to_fp32(in_data.element_bits[15:0]);
            fsnc_pkg::FMT_BF16: v = {in_data.element_bits[15:0], 16'd0};
            default:            v = in_data.element_bits;
        endcase
        case (format_reg)
            fsnc_pkg::FMT_FP16: fmax = fsnc_pkg::FP16_MAX;
            fsnc_pkg::FMT_BF16: fmax = fsnc_pkg::BF16_MAX;
            default:            fmax = fsnc_pkg::FP32_MAX;
        endcase
        sum_next = fsnc_pkg::fp_add(sum_reg, v);
        abs_next = fsnc_pkg::fp_add(abs_reg, {1'b0, v[30:0]});
        flags_next = flags_reg | {v[30:23] == 8'hFF && v[22:0] == 23'd0,
                                  fsnc_pkg::is_nan(v), v[30:0] == 31'd0};
        min_next = min_reg;
        max_next = max_reg;
        mm_valid_next = mm_valid_reg;
        if (!fsnc_pkg::is_nan(v))
        begin
            mm_valid_next = 1'b1;
            if (!mm_valid_reg || fsnc_pkg::fp_less(v, min_reg))
                min_next = v;
            if (!mm_valid_reg || fsnc_pkg::fp_less(max_reg, v))
                max_next = v;
        end
        // Result assembled from the updated state.
        out_next.total_sum     = stats_reg ? sum_next : 32'd0;
        out_next.total_abs_sum = stats_reg ? abs_next : 32'd0;
        out_next.min_value     = stats_reg ? (mm_valid_next ? min_next : fmax) : 32'd0;
        out_next.max_value     = stats_reg ? (mm_valid_next ? max_next : {1'b1, fmax[30:0]})
                                           : 32'd0;
        out_next.saw_zero      = flags_next[0];
        out_next.saw_nan       = flags_next[1];
        out_next.saw_inf       = flags_next[2];
    end

    // Running state; cleared after the last element.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= 32'd0;
            abs_reg      <= 32'd0;
            min_reg      <= 32'd0;
            max_reg      <= 32'd0;
            mm_valid_reg <= 1'b0;
            flags_reg    <= 3'd0;
        end
        else if (accept)
        begin
            if (in_data.last_element)
            begin
                sum_reg      <= 32'd0;
                abs_reg      <= 32'd0;
                min_reg      <= 32'd0;
                max_reg      <= 32'd0;
                mm_valid_reg <= 1'b0;
                flags_reg    <= 3'd0;
            end
            else
            begin
                sum_reg      <= sum_next;
                abs_reg      <= abs_next;
                min_reg      <= min_next;
                max_reg      <= max_next;
                mm_valid_reg <= mm_valid_next;
                flags_reg    <= flags_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && in_data.last_element)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.last_element)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A waiting result is never overwritten by a new last element.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !accept)
        else $error("input taken while result stalled");

    // State is clear after a last element transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last_element |=> flags_reg == 3'd0 && !mm_valid_reg)
        else $error("state not cleared after last element");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(out_reg))
        else $error("stalled result changed");

endmodule
`default_nettype wire
